### hdl/stt_pkg.sv
// shared types, character codes and lookup functions for the text tokenizer
package stt_pkg;

  localparam int unsigned POS_BITS_DEF = 16;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_GAP,
    MODE_WS,
    MODE_WORD,
    MODE_STRING,
    MODE_SLASH,
    MODE_LINECMT,
    MODE_BLOCKCMT
  } scan_mode_e;

  localparam logic [4:0] KIND_WS      = 5'd0;
  localparam logic [4:0] KIND_COMMENT = 5'd1;
  localparam logic [4:0] KIND_TEXT    = 5'd2;
  localparam logic [4:0] KIND_SLASH   = 5'd18;
  localparam logic [4:0] KIND_NONE    = 5'd0;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_UNTERM = 1'b1;

  localparam logic [0:0] CFG_SKIP_TRIVIA = 1'b0;
  localparam logic [0:0] CFG_FIRST_LINE  = 1'b1;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } tok_in_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] span_start;
    logic [15:0] span_length;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic        status_code;
    logic        last_of_run;
  } tok_out_t;

  function automatic logic is_space(logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_NL) || (b == CH_TAB) || (b == CH_CR);
  endfunction

  // kind code of a one-character special, KIND_NONE when the byte is not one
  function automatic logic [4:0] special_kind(logic [7:0] b);
    logic [4:0] k;
    case (b)
      8'h2E:   k = 5'd3;   // .
      8'h2C:   k = 5'd4;   // ,
      8'h3A:   k = 5'd5;   // :
      8'h3B:   k = 5'd6;   // ;
      8'h3D:   k = 5'd7;   // =
      8'h28:   k = 5'd8;   // (
      8'h29:   k = 5'd9;   // )
      8'h7B:   k = 5'd10;  // {
      8'h7D:   k = 5'd11;  // }
      8'h3C:   k = 5'd12;  // <
      8'h3E:   k = 5'd13;  // >
      8'h5B:   k = 5'd14;  // [
      8'h5D:   k = 5'd15;  // ]
      8'h2B:   k = 5'd16;  // +
      8'h2D:   k = 5'd17;  // -
      8'h2F:   k = 5'd18;  // /
      8'h40:   k = 5'd19;  // @
      8'h2A:   k = 5'd20;  // *
      8'h26:   k = 5'd21;  // &
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [15:0] sat_inc16(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

### hdl/source_text_tokenizer_core.sv
// streaming text tokenizer: one byte in, up to two tokens out
//
// Input channel in_valid_i/in_ready_o carries one text byte per word, with
// end_of_text set on the final byte of a text. Output channel
// out_valid_o/out_ready_i carries one token per word; last_of_run marks the
// final token caused by a byte. Bytes that close nothing give no token.
// The scanner updates its mode in the cycle a byte is accepted and pushes
// the tokens it finds into a four-entry output queue; a token is visible on
// the output once the tokens queued before it have been taken.
// Throughput: one byte per cycle while bytes give at most one token each and
// the receiver is ready; a byte that gives two tokens uses the output twice,
// so the drain rate of the single output port sets the sustained rate.
// in_ready_o is high while the queue has room for two tokens, so bytes keep
// flowing while earlier tokens wait; a stalled receiver fills the queue and
// then holds the input off, and no token is dropped.
// Reset empties the queue, clears skip_trivia, sets first_line_number to 1
// and puts the scanner in idle; the next byte starts a new text at offset 0.
// skip_trivia applies from the next byte; first_line_number from the next text.
module source_text_tokenizer_core #(
  parameter int unsigned POSITION_BITS = stt_pkg::POS_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  stt_pkg::tok_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output stt_pkg::tok_out_t out_data_o,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_index_i,
  input  logic [0:0]       cfg_data_i
);
  import stt_pkg::*;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = QPTR_W + 1;
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  typedef logic [POSITION_BITS-1:0] pos_t;

  // configuration
  logic skip_trivia_q;
  logic first_line_q;

  // scanner state
  scan_mode_e  mode_q, mode_d;
  logic        qsingle_q, qsingle_d;
  logic [7:0]  prev_q, prev_d;
  logic [1:0]  cprog_q, cprog_d;
  pos_t        pos_q, pos_d;
  logic [15:0] line_q, line_d;
  logic [15:0] col_q, col_d;
  pos_t        org_pos_q, org_pos_d;
  logic [15:0] org_line_q, org_line_d;
  logic [15:0] org_col_q, org_col_d;

  // output queue
  tok_out_t            queue_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q, count_d;

  logic     in_accept;
  logic     out_pop;
  tok_out_t res0, res1;
  logic [1:0] n_res;

  function automatic tok_out_t mk_tok(logic [4:0] kind, pos_t start, pos_t len,
                                      logic [15:0] line, logic [15:0] col,
                                      logic status);
    tok_out_t t;
    t.token_kind    = kind;
    t.span_start    = 16'(start);
    t.span_length   = 16'(len);
    t.line_number   = line;
    t.column_number = col;
    t.status_code   = status;
    t.last_of_run   = 1'b0;
    return t;
  endfunction

  assign in_ready_o  = (count_q <= QCNT_W'(QDEPTH - 2));
  assign in_accept   = in_valid_i & in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign out_pop     = out_valid_o & out_ready_i;
  assign out_data_o  = queue_q[rd_ptr_q];

  always_comb begin
    logic        idle;
    scan_mode_e  mode_c;
    pos_t        pos_c;
    logic [15:0] line_c;
    logic [15:0] col_c;
    logic [7:0]  prev_c;
    logic [7:0]  b;
    logic        last;
    logic        start_tok;
    logic [4:0]  sk;
    logic        e1_v, e2_v, e3_v;
    tok_out_t    e1, e2, e3;

    b    = in_data_i.data_byte;
    last = in_data_i.end_of_text;
    idle = (mode_q == MODE_IDLE);
    // a new text restarts offset, line and column
    mode_c = idle ? MODE_GAP : mode_q;
    pos_c  = idle ? '0 : pos_q;
    line_c = idle ? {15'd0, first_line_q} : line_q;
    col_c  = idle ? 16'd0 : col_q;
    prev_c = idle ? 8'd0 : prev_q;

    mode_d     = mode_c;
    qsingle_d  = qsingle_q;
    cprog_d    = cprog_q;
    org_pos_d  = org_pos_q;
    org_line_d = org_line_q;
    org_col_d  = org_col_q;
    start_tok  = 1'b0;
    sk         = special_kind(b);
    e1_v = 1'b0;
    e2_v = 1'b0;
    e3_v = 1'b0;
    e1   = '0;
    e2   = '0;
    e3   = '0;

    case (mode_c)
      MODE_WS: begin
        if (!is_space(b)) begin
          e1_v = 1'b1;
          e1 = mk_tok(KIND_WS, org_pos_q, pos_c - org_pos_q, org_line_q, org_col_q,
                      STATUS_OK);
          start_tok = 1'b1;
        end
      end
      MODE_WORD: begin
        if (is_space(b) || (sk != KIND_NONE)) begin
          e1_v = 1'b1;
          e1 = mk_tok(KIND_TEXT, org_pos_q, pos_c - org_pos_q, org_line_q, org_col_q,
                      STATUS_OK);
          start_tok = 1'b1;
        end
      end
      MODE_STRING: begin
        if (b == (qsingle_q ? CH_SQUOTE : CH_DQUOTE)) begin
          e1_v = 1'b1;
          e1 = mk_tok(KIND_TEXT, org_pos_q + POS_ONE, pos_c - org_pos_q - POS_ONE,
                      org_line_q, org_col_q, STATUS_OK);
          mode_d = MODE_GAP;
        end
      end
      MODE_SLASH: begin
        if (b == CH_SLASH) begin
          mode_d = MODE_LINECMT;
        end else if (b == CH_STAR) begin
          mode_d  = MODE_BLOCKCMT;
          cprog_d = 2'd2;
        end else begin
          e1_v = 1'b1;
          e1 = mk_tok(KIND_SLASH, org_pos_q, POS_ONE, org_line_q, org_col_q, STATUS_OK);
          start_tok = 1'b1;
        end
      end
      MODE_LINECMT: begin
        // an escaped newline keeps the comment going
        if ((b == CH_NL) && (prev_c != CH_BSLASH)) begin
          e1_v = 1'b1;
          e1 = mk_tok(KIND_COMMENT, org_pos_q, pos_c - org_pos_q, org_line_q,
                      org_col_q, STATUS_OK);
          start_tok = 1'b1;
        end
      end
      MODE_BLOCKCMT: begin
        if ((cprog_q == 2'd3) && (b == CH_SLASH) && (prev_c == CH_STAR)) begin
          e1_v = 1'b1;
          e1 = mk_tok(KIND_COMMENT, org_pos_q, pos_c + POS_ONE - org_pos_q,
                      org_line_q, org_col_q, STATUS_OK);
          mode_d = MODE_GAP;
        end else if (cprog_q != 2'd3) begin
          cprog_d = cprog_q + 2'd1;
        end
      end
      default: begin
        start_tok = 1'b1;
      end
    endcase

    if (start_tok) begin
      org_pos_d  = pos_c;
      org_line_d = line_c;
      org_col_d  = col_c;
      if (b == CH_SLASH) begin
        mode_d = MODE_SLASH;
      end else if (is_space(b)) begin
        mode_d = MODE_WS;
      end else if (sk != KIND_NONE) begin
        e2_v   = 1'b1;
        e2     = mk_tok(sk, pos_c, POS_ONE, line_c, col_c, STATUS_OK);
        mode_d = MODE_GAP;
      end else if ((b == CH_DQUOTE) || (b == CH_SQUOTE)) begin
        qsingle_d = (b == CH_SQUOTE);
        mode_d    = MODE_STRING;
      end else begin
        mode_d = MODE_WORD;
      end
    end

    prev_d = b;
    pos_d  = pos_c + POS_ONE;
    if (b == CH_NL) begin
      line_d = sat_inc16(line_c);
      col_d  = 16'd0;
    end else begin
      line_d = line_c;
      col_d  = sat_inc16(col_c);
    end

    // close whatever is still open at the end of the text
    if (last) begin
      case (mode_d)
        MODE_WS: begin
          e3_v = 1'b1;
          e3 = mk_tok(KIND_WS, org_pos_d, pos_d - org_pos_d, org_line_d, org_col_d,
                      STATUS_OK);
        end
        MODE_WORD: begin
          e3_v = 1'b1;
          e3 = mk_tok(KIND_TEXT, org_pos_d, pos_d - org_pos_d, org_line_d, org_col_d,
                      STATUS_OK);
        end
        MODE_LINECMT, MODE_BLOCKCMT: begin
          e3_v = 1'b1;
          e3 = mk_tok(KIND_COMMENT, org_pos_d, pos_d - org_pos_d, org_line_d,
                      org_col_d, STATUS_OK);
        end
        MODE_SLASH: begin
          e3_v = 1'b1;
          e3 = mk_tok(KIND_SLASH, org_pos_d, POS_ONE, org_line_d, org_col_d, STATUS_OK);
        end
        MODE_STRING: begin
          e3_v = 1'b1;
          e3 = mk_tok(KIND_TEXT, org_pos_d + POS_ONE, pos_d - org_pos_d - POS_ONE,
                      org_line_d, org_col_d, STATUS_UNTERM);
        end
        default: begin
          e3_v = 1'b0;
        end
      endcase
      mode_d  = MODE_IDLE;
      cprog_d = 2'd0;
    end

    // trivia filter
    if (skip_trivia_q && (e1.token_kind <= KIND_COMMENT)) e1_v = 1'b0;
    if (skip_trivia_q && (e3.token_kind <= KIND_COMMENT)) e3_v = 1'b0;

    // keep the first two tokens in order
    res0  = '0;
    res1  = '0;
    n_res = 2'd0;
    if (e1_v) begin
      res0 = e1;
      if (e2_v) begin
        res1  = e2;
        n_res = 2'd2;
      end else if (e3_v) begin
        res1  = e3;
        n_res = 2'd2;
      end else begin
        n_res = 2'd1;
      end
    end else if (e2_v) begin
      res0 = e2;
      if (e3_v) begin
        res1  = e3;
        n_res = 2'd2;
      end else begin
        n_res = 2'd1;
      end
    end else if (e3_v) begin
      res0  = e3;
      n_res = 2'd1;
    end
    res0.last_of_run = (n_res == 2'd1);
    res1.last_of_run = 1'b1;

    count_d = count_q + QCNT_W'(n_res & {2{in_accept}}) - QCNT_W'(out_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_trivia_q <= 1'b0;
      first_line_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SKIP_TRIVIA: skip_trivia_q <= cfg_data_i[0];
        CFG_FIRST_LINE:  first_line_q  <= cfg_data_i[0];
        default:         skip_trivia_q <= skip_trivia_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      qsingle_q  <= 1'b0;
      prev_q     <= 8'd0;
      cprog_q    <= 2'd0;
      pos_q      <= '0;
      line_q     <= 16'd1;
      col_q      <= 16'd0;
      org_pos_q  <= '0;
      org_line_q <= 16'd0;
      org_col_q  <= 16'd0;
    end else if (in_accept) begin
      mode_q     <= mode_d;
      qsingle_q  <= qsingle_d;
      prev_q     <= prev_d;
      cprog_q    <= cprog_d;
      pos_q      <= pos_d;
      line_q     <= line_d;
      col_q      <= col_d;
      org_pos_q  <= org_pos_d;
      org_line_q <= org_line_d;
      org_col_q  <= org_col_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_accept) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(n_res);
      end
      if (out_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      count_q <= count_d;
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept && (n_res != 2'd0)) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (in_accept && (n_res == 2'd2)) begin
      queue_q[wr_ptr_q + QPTR_W'(1)] <= res1;
    end
  end

endmodule
